[rtl/eobd_pkg.sv]
package eobd_pkg;

	// characters that steer the decoder
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_THREE  = 8'h33;
	localparam logic [7:0] CH_SEVEN  = 8'h37;

	localparam int unsigned PARTIAL_W = 6;

	// decode modes
	typedef enum logic [2:0] {
		M_NORMAL    = 3'd0,
		M_ESC_FIRST = 3'd1,
		M_ESC       = 3'd2,
		M_OCT1      = 3'd3,
		M_OCT2      = 3'd4,
		M_DROP_BAD  = 3'd5,
		M_DROP_HEX  = 3'd6
	} mode_t;

	// closing status codes
	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_BAD = 2'd1,
		ST_HEX = 2'd2
	} status_t;

	// decoder state carried between words
	typedef struct packed {
		mode_t                  mode;
		logic                   at_value_start;
		logic [PARTIAL_W-1:0]   octal_partial;
	} dec_state_t;

	// result of one decode step
	typedef struct packed {
		logic       have;
		logic [7:0] byte_out;
		logic       byte_valid;
		logic       end_of_value;
		status_t    status;
	} dec_result_t;

	localparam dec_state_t STATE_RESET = '{
		mode: M_NORMAL,
		at_value_start: 1'b1,
		octal_partial: '0
	};

endpackage

[rtl/eobd_in_if.sv]
interface eobd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       last_char;

	modport source (output valid, output char_in, output last_char, input ready);
	modport sink (input valid, input char_in, input last_char, output ready);
endinterface

[rtl/eobd_out_if.sv]
interface eobd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic       byte_valid;
	logic       end_of_value;
	logic [1:0] status;

	modport source (output valid, output byte_out, output byte_valid,
		output end_of_value, output status, input ready);
	modport sink (input valid, input byte_out, input byte_valid,
		input end_of_value, input status, output ready);
endinterface

[rtl/eobd_step.sv]
module eobd_step (
	input  eobd_pkg::dec_state_t  state,
	input  logic [7:0]            char_in,
	input  logic                  last_char,
	output eobd_pkg::dec_state_t  next_state,
	output eobd_pkg::dec_result_t result
);

	logic                                is_oct;
	logic                                is_oct_lead;
	logic [2:0]                          digit;
	eobd_pkg::mode_t                     nmode;
	logic [eobd_pkg::PARTIAL_W-1:0]      npartial;
	eobd_pkg::status_t                   err;
	logic                                have;
	logic [7:0]                          byte_val;
	logic [eobd_pkg::PARTIAL_W+2:0]      oct_full;

	// character classes
	assign is_oct      = (char_in >= eobd_pkg::CH_ZERO) && (char_in <= eobd_pkg::CH_SEVEN);
	assign is_oct_lead = (char_in >= eobd_pkg::CH_ZERO) && (char_in <= eobd_pkg::CH_THREE);
	assign digit       = char_in[2:0];
	assign oct_full    = {state.octal_partial, digit};

	// mode transitions
	always_comb begin
		nmode    = state.mode;
		npartial = state.octal_partial;
		err      = eobd_pkg::ST_OK;
		have     = 1'b0;
		byte_val = '0;
		case (state.mode)
			eobd_pkg::M_NORMAL: begin
				if (char_in == eobd_pkg::CH_BSLASH) begin
					nmode = state.at_value_start ? eobd_pkg::M_ESC_FIRST : eobd_pkg::M_ESC;
					err   = eobd_pkg::ST_BAD;
				end else begin
					have     = 1'b1;
					byte_val = char_in;
				end
			end
			eobd_pkg::M_ESC_FIRST, eobd_pkg::M_ESC: begin
				if (char_in == eobd_pkg::CH_BSLASH) begin
					have     = 1'b1;
					byte_val = eobd_pkg::CH_BSLASH;
					nmode    = eobd_pkg::M_NORMAL;
				end else if (is_oct_lead) begin
					npartial = {{(eobd_pkg::PARTIAL_W-3){1'b0}}, digit};
					nmode    = eobd_pkg::M_OCT1;
					err      = eobd_pkg::ST_BAD;
				end else if (state.mode == eobd_pkg::M_ESC_FIRST &&
						char_in == eobd_pkg::CH_X) begin
					nmode = eobd_pkg::M_DROP_HEX;
					err   = eobd_pkg::ST_HEX;
				end else begin
					nmode = eobd_pkg::M_DROP_BAD;
					err   = eobd_pkg::ST_BAD;
				end
			end
			eobd_pkg::M_OCT1: begin
				if (is_oct) begin
					npartial = oct_full[eobd_pkg::PARTIAL_W-1:0];
					nmode    = eobd_pkg::M_OCT2;
				end else begin
					nmode = eobd_pkg::M_DROP_BAD;
				end
				err = eobd_pkg::ST_BAD;
			end
			eobd_pkg::M_OCT2: begin
				if (is_oct) begin
					have     = 1'b1;
					byte_val = oct_full[7:0];
					nmode    = eobd_pkg::M_NORMAL;
					npartial = '0;
				end else begin
					nmode = eobd_pkg::M_DROP_BAD;
					err   = eobd_pkg::ST_BAD;
				end
			end
			eobd_pkg::M_DROP_HEX: begin
				err = eobd_pkg::ST_HEX;
			end
			default: begin
				nmode = eobd_pkg::M_DROP_BAD;
				err   = eobd_pkg::ST_BAD;
			end
		endcase
	end

	// closing on the last character
	always_comb begin
		result.have         = have;
		result.byte_out     = byte_val;
		result.byte_valid   = have;
		result.end_of_value = last_char;
		result.status       = eobd_pkg::ST_OK;
		if (last_char) begin
			next_state = eobd_pkg::STATE_RESET;
			if (!have) begin
				result.have   = 1'b1;
				result.status = err;
			end
		end else begin
			next_state.mode           = nmode;
			next_state.at_value_start = 1'b0;
			next_state.octal_partial  = npartial;
		end
	end

endmodule

[rtl/escaped_octal_byte_decoder.sv]
// channel  | dir | payload                                   | word
// in_ch    | in  | char_in[7:0], last_char                   | one character
// out_ch   | out | byte_out[7:0], byte_valid, end_of_value,  | one decoded byte
//          |     | status[1:0]                               | or closing status
//
// one character per cycle unless the output stalls; results register after stage 1
// the decode state register loops back to itself through one step of logic
// arst_n clears the input stage, the decode state and the result register
// a stalled result holds stage 1 and the input, also for characters that give no result
module escaped_octal_byte_decoder (
	input  logic          clk,
	input  logic          arst_n,
	eobd_in_if.sink       in_ch,
	eobd_out_if.source    out_ch
);

	logic                  valid_s1;
	logic [7:0]            char_s1;
	logic                  last_s1;
	eobd_pkg::dec_state_t  state_q;
	eobd_pkg::dec_state_t  next_state;
	eobd_pkg::dec_result_t step_res;
	logic                  res_valid_q;
	logic [7:0]            byte_q;
	logic                  byte_valid_q;
	logic                  end_q;
	eobd_pkg::status_t     status_q;
	logic                  advance;

	// stage 1 moves on when the result register is free or drains
	assign advance     = valid_s1 && (!res_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			char_s1 <= in_ch.char_in;
			last_s1 <= in_ch.last_char;
		end
	end

	eobd_step u_step (
		.state      (state_q),
		.char_in    (char_s1),
		.last_char  (last_s1),
		.next_state (next_state),
		.result     (step_res)
	);

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eobd_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= next_state;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && step_res.have) begin
			res_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res.have) begin
			byte_q       <= step_res.byte_out;
			byte_valid_q <= step_res.byte_valid;
			end_q        <= step_res.end_of_value;
			status_q     <= step_res.status;
		end
	end

	assign out_ch.valid        = res_valid_q;
	assign out_ch.byte_out     = byte_q;
	assign out_ch.byte_valid   = byte_valid_q;
	assign out_ch.end_of_value = end_q;
	assign out_ch.status       = status_q;

	// a closing character returns the decoder to its start state
	a_close_resets: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> state_q.mode == eobd_pkg::M_NORMAL &&
			state_q.at_value_start && state_q.octal_partial == '0)
		else $error("state not cleared after closing word");

	// an error status only rides on a closing word without a byte
	a_err_closes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && status_q != eobd_pkg::ST_OK |-> end_q && !byte_valid_q)
		else $error("error status on non-closing word");

	// a word without a byte is always a closing word
	a_nobyte_closes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !byte_valid_q |-> end_q)
		else $error("empty word that does not close");

	// a held character in stage 1 blocks new input
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> !in_ch.ready)
		else $error("stage 1 overwritten while held");

	// the first character of a value is seen only in the start state
	a_start_mode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.at_value_start |-> state_q.mode == eobd_pkg::M_NORMAL)
		else $error("value start outside normal mode");

endmodule
